// File: src/mining_share_target_check_unit_assert.svh
// assertion macros for the checker file mstc_chk.sv
`ifndef MINING_SHARE_TARGET_CHECK_UNIT_ASSERT_SVH
`define MINING_SHARE_TARGET_CHECK_UNIT_ASSERT_SVH

// property checked on every rising clock edge, off while reset is low
`define MSTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same with an explicit clock and reset
`define MSTC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`endif

// File: src/mstc_pkg.sv
package mstc_pkg;

  localparam int unsigned CmpW     = 32;
  localparam int unsigned TgtW     = 64;
  localparam int unsigned HalfW    = TgtW / 2;
  localparam int unsigned CntW     = 6;
  localparam int unsigned StepsDen = 32;
  localparam int unsigned StepsTgt = 64;

  localparam logic [CmpW-1:0] AllOnes32 = '1;
  localparam logic [TgtW-1:0] AllOnes64 = '1;

  typedef enum logic [1:0] {
    EXP_IDLE,
    EXP_DENOM,
    EXP_TARGET
  } exp_state_e;

  // expanded target as seen by the compare pipeline
  typedef struct packed {
    logic            nz;
    logic [TgtW-1:0] value;
  } mstc_tgt_t;

endpackage

// File: src/mstc_expand.sv
module mstc_expand (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_data_i,
  output logic                   busy_o,
  output mstc_pkg::mstc_tgt_t    tgt_o
);
  import mstc_pkg::*;

  exp_state_e        state_q, state_d;
  logic [CntW-1:0]   cnt_q;
  logic [CmpW-1:0]   div_q;
  logic [CmpW-1:0]   rem_q;
  logic [TgtW-1:0]   dq_q;
  logic [TgtW-1:0]   tgt_q;
  logic              nz_q;

  logic [CmpW:0]     part;
  logic [CmpW:0]     diff;
  logic              qbit;
  logic [CmpW-1:0]   rem_nx;
  logic [TgtW-1:0]   dq_nx;

  // one restoring step: shift in the next dividend bit, trial subtract
  always_comb begin
    part   = {rem_q, dq_q[TgtW-1]};
    diff   = part - {1'b0, div_q};
    qbit   = ~diff[CmpW];
    rem_nx = qbit ? diff[CmpW-1:0] : part[CmpW-1:0];
    dq_nx  = {dq_q[TgtW-2:0], qbit};
  end

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = (cfg_data_i == '0) ? EXP_IDLE : EXP_DENOM;
    end else begin
      unique case (state_q)
        EXP_IDLE:   state_d = EXP_IDLE;
        EXP_DENOM:  if (cnt_q == '0) state_d = EXP_TARGET;
        EXP_TARGET: if (cnt_q == '0) state_d = EXP_IDLE;
        default:    state_d = EXP_IDLE;
      endcase
    end
  end

  always_comb begin
    busy_o      = (state_q != EXP_IDLE);
    tgt_o.nz    = nz_q;
    tgt_o.value = tgt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EXP_IDLE;
      cnt_q   <= '0;
      tgt_q   <= '0;
      nz_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cnt_q <= CntW'(StepsDen - 1);
        tgt_q <= '0;
        nz_q  <= 1'b0;
      end else if (state_q == EXP_DENOM && cnt_q == '0) begin
        cnt_q <= CntW'(StepsTgt - 1);
      end else if (state_q == EXP_TARGET && cnt_q == '0) begin
        tgt_q <= dq_nx;
        nz_q  <= 1'b1;
      end else if (state_q != EXP_IDLE) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (cfg_we_i) begin
      div_q <= cfg_data_i;
      rem_q <= '0;
      dq_q  <= {AllOnes32, {HalfW{1'b0}}};
    end else if (state_q == EXP_DENOM && cnt_q == '0) begin
      // quotient of the first pass becomes the divisor of the second
      div_q <= dq_nx[CmpW-1:0];
      rem_q <= '0;
      dq_q  <= AllOnes64;
    end else if (state_q != EXP_IDLE) begin
      rem_q <= rem_nx;
      dq_q  <= dq_nx;
    end
  end

endmodule

// File: src/mstc_pipe.sv
module mstc_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_i,
  input  logic [63:0]            hash_tail_word_i,
  input  logic                   hash_short_i,
  input  mstc_pkg::mstc_tgt_t    tgt_i,
  output logic                   done_o,
  output logic                   share_ok_o,
  output logic [63:0]            full_target_o
);
  import mstc_pkg::*;

  // stage 1: tail select
  logic              v1_q;
  logic [TgtW-1:0]   tail1_q;
  // stage 2: half-word compares
  logic              v2_q;
  logic              hi_lt2_q, hi_eq2_q, lo_le2_q;
  mstc_tgt_t         tgt2_q;
  // stage 3: result
  logic              v3_q;
  logic              ok3_q;
  logic [TgtW-1:0]   tgt3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tail1_q  <= hash_short_i ? AllOnes64 : hash_tail_word_i;
    hi_lt2_q <= tail1_q[TgtW-1:HalfW] <  tgt_i.value[TgtW-1:HalfW];
    hi_eq2_q <= tail1_q[TgtW-1:HalfW] == tgt_i.value[TgtW-1:HalfW];
    lo_le2_q <= tail1_q[HalfW-1:0]    <= tgt_i.value[HalfW-1:0];
    tgt2_q   <= tgt_i;
    ok3_q    <= tgt2_q.nz & (hi_lt2_q | (hi_eq2_q & lo_le2_q));
    tgt3_q   <= tgt2_q.value;
  end

  assign done_o        = v3_q;
  assign share_ok_o    = ok3_q;
  assign full_target_o = tgt3_q;

endmodule

// File: src/mining_share_target_check_unit.sv
// a request taken at a clock edge passes stage registers v1_q, v2_q and v3_q to done_o
// throughput: one request per cycle while busy_o is low, results cannot be held off
// a nonzero compact target write holds busy_o high in the write cycle and
// through the 32 + 64 divider steps after it; a zero write only in its cycle
// reset (rst_ni low, asynchronous) drops all requests in flight, target = 0
module mining_share_target_check_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] hash_tail_word_i,
  input  logic        hash_short_i,
  // compact target register
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  // result side
  output logic        done_o,
  output logic        share_ok_o,
  output logic [63:0] full_target_o
);
  import mstc_pkg::*;

  logic      exp_busy;
  mstc_tgt_t tgt;
  logic      req;

  // target expansion: two restoring divisions on one shared 32-bit
  // subtract, first 0xffffffff / raw then all ones (64 bits) / denom
  mstc_expand u_expand (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (exp_busy),
    .tgt_o      (tgt)
  );

  // a write cycle also blocks a request so the new target applies to it
  assign busy_o = exp_busy | cfg_we_i;
  assign req    = start_i & ~busy_o;

  // three-stage compare: tail select, half compares, combine
  mstc_pipe u_pipe (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .hash_tail_word_i (hash_tail_word_i),
    .hash_short_i     (hash_short_i),
    .tgt_i            (tgt),
    .done_o           (done_o),
    .share_ok_o       (share_ok_o),
    .full_target_o    (full_target_o)
  );

endmodule

// File: src/mstc_chk.sv
`include "mining_share_target_check_unit_assert.svh"

module mstc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        hash_short_i,
  input logic        cfg_we_i,
  input logic [31:0] cfg_data_i,
  input logic        done_o,
  input logic        share_ok_o,
  input logic [63:0] full_target_o
);

  logic req;
  logic short_req;
  assign req       = start_i && !busy_o;
  assign short_req = req && hash_short_i;

  // every request gets its result on done_o
  `MSTC_ASSERT(a_req_done, req |-> ##3 done_o, "request without result")

  // no result on done_o without an earlier request
  `MSTC_ASSERT(a_done_req, done_o |-> $past(req, 3), "result without request")

  // an accepted share needs a nonzero target
  `MSTC_ASSERT(a_ok_nz, (done_o && share_ok_o) |-> (full_target_o != 64'd0),
    "share accepted with zero target")

  // a short hash passes only on an all-ones target
  `MSTC_ASSERT_CLK(a_short, clk_i, rst_ni,
    (done_o && $past(short_req, 3)) |-> (share_ok_o == (full_target_o == '1)),
    "short hash result wrong")

  // a nonzero target write is followed by busy_o high, keeping requests out as expansion starts
  `MSTC_ASSERT(a_cfg_busy, (cfg_we_i && (cfg_data_i != 32'd0)) |=> busy_o,
    "request side open during target expansion")

endmodule

bind mining_share_target_check_unit mstc_chk u_mstc_chk (.*);
